// ===== hdl/cam_pkg.sv =====
package cam_pkg;

    // Field widths of one transaction
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int LEN_W    = 16;

    // Packed stream widths, rounded up to whole bytes
    localparam int IN_W  = 56;
    localparam int OUT_W = 40;

    localparam int LENGTH_BITS_DEF = 16;

    localparam logic [MINUTE_W-1:0] MIN_PER_HOUR = 6'd60;
    localparam logic [MINUTE_W-1:0] HOUR_PER_DAY = 6'd24;

    // Reciprocals for division by constants. ceil(2^23 / 60) is exact for
    // dividends below 2^17; ceil(2^9 / 3) is exact for dividends below 2^9.
    localparam int          DIV60_SHIFT = 23;
    localparam logic [17:0] DIV60_MUL   = 18'd139811;
    localparam int          DIV3_SHIFT  = 9;
    localparam logic [7:0]  DIV3_MUL    = 8'd171;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIN_QUOT,
        ST_MIN_REM,
        ST_HOUR_QUOT,
        ST_HOUR_REM,
        ST_MONTH,
        ST_DONE
    } state_t;

    // Gregorian leap rule. Divisibility by 25 is found by folding the year
    // with 128 = 3 (mod 25) and 32 = 7 (mod 25), then matching multiples.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [8:0] s1;
        logic [7:0] s2;
        logic       z25;
        s1  = 9'(y[13:7]) * 9'd3 + 9'(y[6:0]);
        s2  = 8'(s1[8:5]) * 8'd7 + 8'(s1[4:0]);
        z25 = (s2 == 8'd0) || (s2 == 8'd25) || (s2 == 8'd50) || (s2 == 8'd75) ||
              (s2 == 8'd100) || (s2 == 8'd125);
        return (y[1:0] == 2'd0) && (!z25 || (y[3:0] == 4'd0));
    endfunction

    // Days in a month; the month is already clamped to 1..12
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic [YEAR_W-1:0]  y);
        logic [DAY_W-1:0] d;
        case (m) inside
            MONTH_FEB:                     d = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:       d = 5'd30;
            default:                       d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

// ===== hdl/calendar_add_minutes_core.sv =====
// Steps: ST_MIN_QUOT, ST_MIN_REM, ST_HOUR_QUOT, ST_HOUR_REM, ST_MONTH for each month end
//   crossed (0..2) and one final check, then ST_DONE until the output register is free.
//   s_tready is high only while idle. Each division takes a reciprocal multiply step and
//   a remainder step on the shared subtractor, which then checks one month end per cycle.
// Reset: rst_n is asynchronous, active low; it returns the sequencer to idle
//   and drops m_tvalid. Datapath registers are not reset.
module calendar_add_minutes_core
    import cam_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    // Input stream
    input  logic             s_tvalid,
    output logic             s_tready,
    // start_day[4:0], start_month[8:5], start_year[22:9], start_hour[27:23],
    // start_minute[33:28], length_minutes[49:34], zero fill [55:50]
    input  logic [IN_W-1:0]  s_tdata,
    // Output stream
    output logic             m_tvalid,
    input  logic             m_tready,
    // end_day[4:0], end_month[8:5], end_year[22:9], end_hour[27:23],
    // end_minute[33:28], zero fill [39:34]
    output logic [OUT_W-1:0] m_tdata
);

    // Only the low LENGTH_BITS of the duration count, and the field has 16.
    localparam int LB = (LENGTH_BITS < LEN_W) ? LENGTH_BITS : LEN_W;
    // Minute total, hour total and day total all fit in LB+1 bits when LB is at least 6.
    localparam int MW = LB + 1;

    state_t               state_reg, state_next;
    logic [MW-1:0]        acc_reg, acc_next;    // dividend of the current division
    logic [MW-1:0]        quot_reg, quot_next;  // quotient of the current division
    logic [MW-1:0]        day_reg, day_next;
    logic [MONTH_W-1:0]   month_reg, month_next;
    logic [YEAR_W-1:0]    year_reg, year_next;
    logic [HOUR_W-1:0]    hour_reg, hour_next;
    logic [MINUTE_W-1:0]  minute_reg, minute_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]     m_tdata_reg, m_tdata_next;

    logic [MW-1:0]        unit_a, unit_b, unit_diff;
    logic                 unit_ge;
    logic [MW+17:0]       min_prod;
    logic [MW+4:0]        hour_prod;
    logic [MW-1:0]        min_quot;
    logic [MW-1:0]        hour_quot;
    logic [DAY_W-1:0]     max_day;
    logic [MONTH_W-1:0]   in_month;

    // Shared subtract/compare unit: division remainders and month rollover
    cam_sub #(
        .W (MW)
    ) u_sub (
        .a    (unit_a),
        .b    (unit_b),
        .diff (unit_diff),
        .ge   (unit_ge)
    );

    // Quotient by 60 through a reciprocal multiply
    assign min_prod = (MW+18)'(acc_reg) * (MW+18)'(DIV60_MUL);
    assign min_quot = MW'(min_prod[MW+17:DIV60_SHIFT]);

    // Quotient by 24: drop three bits (divide by 8), then divide by 3
    assign hour_prod = (MW+5)'(acc_reg[MW-1:3]) * (MW+5)'(DIV3_MUL);
    assign hour_quot = MW'(hour_prod[MW+4:DIV3_SHIFT]);

    assign max_day = month_len(month_reg, year_reg);

    // Clamp the start month into 1..12
    always_comb
    begin
        in_month = s_tdata[8:5];
        if (in_month == '0)
        begin
            in_month = MONTH_JAN;
        end
        else if (in_month > MONTH_DEC)
        begin
            in_month = MONTH_DEC;
        end
    end

    // Operand select for the shared unit
    always_comb
    begin
        unit_a = acc_reg;
        unit_b = quot_reg * MW'(HOUR_PER_DAY);
        if (state_reg == ST_MONTH)
        begin
            unit_a = day_reg;
            unit_b = MW'(max_day);
        end
        else if (state_reg == ST_MIN_REM)
        begin
            unit_b = quot_reg * MW'(MIN_PER_HOUR);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        quot_next     = quot_reg;
        day_next      = day_reg;
        month_next    = month_reg;
        year_next     = year_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        s_tready      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    // Load the start fields; minute total seeds the first division
                    acc_next   = MW'(s_tdata[33:28]) + MW'(s_tdata[34 +: LB]);
                    day_next   = MW'(s_tdata[4:0]);
                    month_next = in_month;
                    year_next  = s_tdata[22:9];
                    hour_next  = s_tdata[27:23];
                    state_next = ST_MIN_QUOT;
                end
            end

            ST_MIN_QUOT:
            begin
                quot_next  = min_quot;
                state_next = ST_MIN_REM;
            end

            ST_MIN_REM:
            begin
                // Minute is what is left after whole hours; carry them into the hour total
                minute_next = unit_diff[MINUTE_W-1:0];
                acc_next    = quot_reg + MW'(hour_reg);
                state_next  = ST_HOUR_QUOT;
            end

            ST_HOUR_QUOT:
            begin
                quot_next  = hour_quot;
                state_next = ST_HOUR_REM;
            end

            ST_HOUR_REM:
            begin
                hour_next  = unit_diff[HOUR_W-1:0];
                day_next   = day_reg + quot_reg;
                state_next = ST_MONTH;
            end

            ST_MONTH:
            begin
                // Advance one month while the day exceeds the month length
                if (unit_ge && (unit_diff != '0))
                begin
                    day_next = unit_diff;
                    if (month_reg == MONTH_DEC)
                    begin
                        month_next = MONTH_JAN;
                        year_next  = year_reg + 1'b1;
                    end
                    else
                    begin
                        month_next = month_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, minute_reg, hour_reg, year_reg, month_reg,
                                     day_reg[DAY_W-1:0]};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        quot_reg    <= quot_next;
        day_reg     <= day_next;
        month_reg   <= month_next;
        year_reg    <= year_next;
        hour_reg    <= hour_next;
        minute_reg  <= minute_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hdl/cam_sub.sv =====
module cam_sub #(
    parameter int W = 17
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] diff,
    output logic         ge
);

    logic borrow;

    // One subtract serves every compare: a >= b when no borrow
    assign {borrow, diff} = {1'b0, a} - {1'b0, b};
    assign ge             = !borrow;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import cam_pkg::*;

    typedef struct packed {
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [LEN_W-1:0]    length;
    } start_t;

    typedef struct packed {
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } end_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    // start_day, start_month, start_year, start_hour, start_minute, length_minutes, zero fill
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    // end_day, end_month, end_year, end_hour, end_minute, zero fill
    logic [OUT_W-1:0] m_tdata;

    // End times still owed by the block, oldest first
    end_t end_times_q[$];
    int   fail_count;
    int   send_idle_pct;
    int   recv_stall_pct;

    calendar_add_minutes_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Safety net: a correct run ends far sooner than this
    initial
    begin
        #20ms;
        $display("tb NOT OK");
        $finish;
    end

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        if (m == MONTH_FEB)
            return leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // Compute the end date and time for one start item
    function automatic end_t add_minutes(input start_t s);
        int unsigned day;
        int unsigned month;
        int unsigned year;
        int unsigned hour;
        int unsigned minute;
        int unsigned mlen;
        end_t        e;
        day    = s.day;
        month  = s.month;
        year   = s.year;
        hour   = s.hour;
        minute = s.minute + s.length;
        // Clamp the month into 1..12 before any lookup
        if (month == 0)
            month = MONTH_JAN;
        if (month > MONTH_DEC)
            month = MONTH_DEC;
        hour   = hour + minute / 60;
        minute = minute % 60;
        day    = day + hour / 24;
        hour   = hour % 24;
        mlen   = days_in_month(month, year);
        // Roll whole days over month ends; the year wraps at 14 bits
        while (day > mlen)
        begin
            day   = day - mlen;
            month = month + 1;
            if (month > MONTH_DEC)
            begin
                month = MONTH_JAN;
                year  = (year + 1) & ((1 << YEAR_W) - 1);
            end
            mlen = days_in_month(month, year);
        end
        e.day    = DAY_W'(day);
        e.month  = MONTH_W'(month);
        e.year   = YEAR_W'(year);
        e.hour   = HOUR_W'(hour);
        e.minute = MINUTE_W'(minute);
        return e;
    endfunction

    function automatic start_t make_start(input int unsigned d, input int unsigned m,
                                          input int unsigned y, input int unsigned h,
                                          input int unsigned mi, input int unsigned len);
        start_t s;
        s.day    = DAY_W'(d);
        s.month  = MONTH_W'(m);
        s.year   = YEAR_W'(y);
        s.hour   = HOUR_W'(h);
        s.minute = MINUTE_W'(mi);
        s.length = LEN_W'(len);
        return s;
    endfunction

    // Build one random start item. Most items are well-formed dates; some sit
    // just before a month end to force roll-overs, the rest are raw noise.
    function automatic start_t random_start();
        start_t      s;
        int unsigned y;
        case ($urandom_range(9))
            0:
            begin
                s = make_start($urandom_range(31), $urandom_range(15), $urandom_range(16383),
                               $urandom_range(31), $urandom_range(63), $urandom_range(65535));
            end
            1, 2, 3:
            begin
                case ($urandom_range(6))
                    0: y = 1900;
                    1: y = 2000;
                    2: y = 2023;
                    3: y = 2024;
                    4: y = 2100;
                    5: y = 16383;
                    default: y = $urandom_range(9999);
                endcase
                s = make_start($urandom_range(27, 31), $urandom_range(1, 12), y,
                               $urandom_range(20, 23), $urandom_range(40, 59),
                               $urandom_range(3000));
            end
            default:
            begin
                s = make_start($urandom_range(1, 31), $urandom_range(1, 12),
                               $urandom_range(9999), $urandom_range(23), $urandom_range(59),
                               $urandom_range(1) ? $urandom_range(65535) : $urandom_range(2880));
            end
        endcase
        return s;
    endfunction

    // Drive one start item and hold it until the block takes it
    task automatic send_start(input start_t s);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - LEN_W - MINUTE_W - HOUR_W - YEAR_W - MONTH_W - DAY_W){1'b0}},
                     s.length, s.minute, s.hour, s.year, s.month, s.day};
        do
            @(posedge clk);
        while (!s_tready);
        end_times_q.push_back(add_minutes(s));
    endtask

    // Drop valid and wait for every owed end time
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (end_times_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int count);
        repeat (count)
            send_start(random_start());
        drain();
    endtask

    task automatic test_corner_dates();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_start(make_start(0, 0, 0, 0, 0, 0));              // day zero, month zero
        send_start(make_start(31, 15, 16383, 31, 63, 65535));  // every field at its top
        send_start(make_start(15, 13, 2001, 10, 30, 0));       // month above December
        send_start(make_start(10, 5, 2010, 31, 63, 0));        // hour and minute overflow
        send_start(make_start(0, 3, 2010, 23, 59, 1));         // day zero with a carry
        send_start(make_start(31, 12, 16383, 23, 59, 1));      // year counter wraps
        send_start(make_start(31, 12, 9999, 23, 59, 1));       // into year 10000
        send_start(make_start(28, 2, 2000, 23, 59, 1));        // leap by 400
        send_start(make_start(28, 2, 1900, 12, 0, 1440));      // century, not leap
        send_start(make_start(28, 2, 2023, 0, 0, 1440));
        send_start(make_start(29, 2, 2024, 0, 0, 1440));
        send_start(make_start(28, 2, 2100, 6, 0, 1440));
        send_start(make_start(28, 2, 2400, 6, 0, 1440));
        send_start(make_start(30, 2, 2023, 8, 15, 0));         // start day past month end
        send_start(make_start(31, 4, 2022, 8, 15, 0));
        send_start(make_start(1, 1, 2022, 0, 0, 65535));       // longest duration
        send_start(make_start(31, 1, 2024, 31, 63, 65535));    // several month ends
        send_start(make_start(31, 11, 16383, 31, 63, 65535));  // wrap after long carry
        send_start(make_start(14, 7, 1234, 12, 34, 321));
        drain();
    endtask

    task automatic test_back_to_back();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(320);
    endtask

    task automatic test_sparse_input();
        send_idle_pct  = 81;
        recv_stall_pct = 0;
        run_random(320);
    endtask

    task automatic test_receiver_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 81;
        run_random(320);
    endtask

    task automatic test_both_sides_idle();
        send_idle_pct  = 36;
        recv_stall_pct = 36;
        run_random(320);
    endtask

    // Stall the result side at random, one decision per cycle
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Match each result transaction against the oldest owed end time
    always @(posedge clk)
    begin
        end_t got;
        end_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{day: m_tdata[4:0], month: m_tdata[8:5], year: m_tdata[22:9],
                    hour: m_tdata[27:23], minute: m_tdata[33:28]};
            if (end_times_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result %0d-%0d-%0d %0d:%0d", got.year, got.month,
                             got.day, got.hour, got.minute);
            end
            else
            begin
                want = end_times_q.pop_front();
                if (got.day !== want.day || got.month !== want.month ||
                    got.year !== want.year || got.hour !== want.hour ||
                    got.minute !== want.minute)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected %0d-%0d-%0d %0d:%0d, got %0d-%0d-%0d %0d:%0d",
                                 want.year, want.month, want.day, want.hour, want.minute,
                                 got.year, got.month, got.day, got.hour, got.minute);
                end
            end
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_corner_dates();
        test_back_to_back();
        test_sparse_input();
        test_receiver_backpressure();
        test_both_sides_idle();

        // Catch any stray result after the last owed one
        repeat (60)
            @(posedge clk);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
